[rtl/core/rcs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rcs_pkg;

  // Default depth of the brace quantifier buffer.
  localparam int unsigned BraceDepthDef = 8;

  localparam logic [7:0] ParenMax = 8'hFF;

  // Characters with a meaning of their own.
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLBracket  = 8'h5B;
  localparam logic [7:0] ChRBracket  = 8'h5D;
  localparam logic [7:0] ChLParen    = 8'h28;
  localparam logic [7:0] ChRParen    = 8'h29;
  localparam logic [7:0] ChLBrace    = 8'h7B;
  localparam logic [7:0] ChRBrace    = 8'h7D;
  localparam logic [7:0] ChPlus      = 8'h2B;
  localparam logic [7:0] ChStar      = 8'h2A;
  localparam logic [7:0] ChQuest     = 8'h3F;
  localparam logic [7:0] ChCaret     = 8'h5E;
  localparam logic [7:0] ChDollar    = 8'h24;
  localparam logic [7:0] ChLowB      = 8'h62;
  localparam logic [7:0] ChUpB       = 8'h42;
  localparam logic [7:0] ChComma     = 8'h2C;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChNine      = 8'h39;

  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StPreFlush,
    StChar,
    StPostFlush
  } rcs_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load;
    logic sel_char;
    logic idx_inc;
    logic run_end;
  } rcs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pre_flush;
    logic do_char;
    logic post_flush;
    logic idx_last;
    logic out_free;
  } rcs_stat_t;

endpackage

`default_nettype wire

[rtl/core/rcs_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_expr;

  modport source (output valid, output char_in, output end_of_expr, input ready);
  modport sink   (input valid, input char_in, input end_of_expr, output ready);
endinterface

`default_nettype wire

[rtl/core/rcs_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       new_part;
  logic       last_of_run;

  modport source (output valid, output char_out, output new_part, output last_of_run,
                  input ready);
  modport sink   (input valid, input char_out, input new_part, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/regex_component_splitter.sv]
// Regular expression component splitter.
//
// The input channel carries one expression character a beat, with
// end_of_expr marking the final character. The output channel echoes the
// characters as a component list: new_part flags a beat that opens a new
// component and last_of_run flags the final beat caused by one input beat.
// Brace quantifiers such as {2,5} are held in an internal buffer and
// appended to the current component when they close; a malformed or
// overfull group is given up and sent on as literal characters.
//
// An input beat is taken only while the controller is idle. Each beat then
// passes through a setup state, so that the buffer read port settles, and
// then sends its output beats, the buffered ones read one entry per cycle,
// while the output register is free: none for a buffered character, up
// to the whole buffer and the character itself when a full buffer is
// flushed. The output register lets the next input beat be taken while
// the last result waits. A stalled receiver holds the sequence; nothing
// is dropped. Reset clears the parser flags, the parenthesis depth, the
// buffer fill count and the output valid flag, but not the buffer contents.
`timescale 1ns / 1ps
`default_nettype none

module regex_component_splitter
  import rcs_pkg::*;
#(
  parameter int unsigned BraceDepth = BraceDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rcs_in_if.sink    in_i,
  rcs_out_if.source out_o
);

  rcs_cmd_t  cmd;
  rcs_stat_t stat;

  // The controller sequences the beats of one input item.
  rcs_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath keeps the parser flags, the brace buffer and the output
  // register.
  rcs_datapath #(
    .BraceDepth (BraceDepth)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .char_in_i     (in_i.char_in),
    .end_of_expr_i (in_i.end_of_expr),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .char_out_o    (out_o.char_out),
    .new_part_o    (out_o.new_part),
    .last_of_run_o (out_o.last_of_run)
  );

endmodule

`default_nettype wire

[rtl/core/rcs_controller.sv]
`timescale 1ns / 1ps
`default_nettype none

module rcs_controller
  import rcs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire rcs_stat_t stat_i,
  output rcs_cmd_t       cmd_o
);

  rcs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StSetup;
        end
      end
      // The setup state lets the buffer read port settle on the first entry.
      StSetup: begin
        if (stat_i.pre_flush) begin
          state_d = StPreFlush;
        end else if (stat_i.do_char) begin
          state_d = StChar;
        end else if (stat_i.post_flush) begin
          state_d = StPostFlush;
        end else begin
          state_d = StIdle;
        end
      end
      StPreFlush: begin
        if (stat_i.out_free) begin
          cmd_o.load    = 1'b1;
          cmd_o.idx_inc = 1'b1;
          if (stat_i.idx_last) begin
            state_d = StChar;
          end
        end
      end
      StChar: begin
        if (stat_i.out_free) begin
          cmd_o.load     = 1'b1;
          cmd_o.sel_char = 1'b1;
          cmd_o.run_end  = !stat_i.post_flush;
          state_d        = stat_i.post_flush ? StPostFlush : StIdle;
        end
      end
      StPostFlush: begin
        if (stat_i.out_free) begin
          cmd_o.load    = 1'b1;
          cmd_o.idx_inc = 1'b1;
          if (stat_i.idx_last) begin
            cmd_o.run_end = 1'b1;
            state_d       = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/rcs_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module rcs_datapath
  import rcs_pkg::*;
#(
  parameter int unsigned BraceDepth = BraceDepthDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire rcs_cmd_t   cmd_i,
  output rcs_stat_t       stat_o,
  input  wire logic [7:0] char_in_i,
  input  wire logic       end_of_expr_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      char_out_o,
  output logic            new_part_o,
  output logic            last_of_run_o
);

  localparam int unsigned IdxW = (BraceDepth > 1) ? $clog2(BraceDepth) : 1;
  localparam int unsigned CntW = $clog2(BraceDepth + 1);

  // Parser flags.
  logic            escape_q, escape_d;
  logic            caret_q, caret_d;
  logic            word_q, word_d;
  logic            nword_q, nword_d;
  logic            bracket_q, bracket_d;
  logic [7:0]      paren_q, paren_d;
  logic            pending_q, pending_d;
  logic            has_digit_q, has_digit_d;
  logic            has_comma_q, has_comma_d;
  logic [CntW-1:0] count_q, count_d;
  logic            comp_open_q, comp_open_d;

  // Plan of the current item's beats.
  logic            pre_q, do_char_q, post_q;
  logic            flush_app_q, char_app_q;
  logic [CntW-1:0] len_q;
  logic [7:0]      char_q;
  logic            eoe_q;
  logic [IdxW-1:0] idx_q, idx_d;

  logic            plan_pre, plan_char, plan_post;
  logic            plan_flush_app, plan_char_app;
  logic [CntW-1:0] plan_len;
  logic            wr_en;
  logic            multi, brace_full, is_digit, is_comma, brace_ok;

  logic [7:0]      store_q [BraceDepth];
  logic [7:0]      rdata_q;

  logic            out_valid_q;
  logic [7:0]      out_char_q;
  logic            out_new_q, out_last_q;
  logic            out_free, beat_app;

  assign multi = bracket_q || (paren_q != '0) || escape_q || caret_q || word_q || nword_q;
  assign brace_full = (count_q >= CntW'(BraceDepth));
  assign is_digit   = (char_in_i >= ChZero) && (char_in_i <= ChNine);
  assign is_comma   = (char_in_i == ChComma);
  assign brace_ok   = is_digit || (is_comma && has_digit_q && !has_comma_q);

  always_comb begin
    escape_d       = escape_q;
    caret_d        = caret_q;
    word_d         = word_q;
    nword_d        = nword_q;
    bracket_d      = bracket_q;
    paren_d        = paren_q;
    pending_d      = pending_q;
    has_digit_d    = has_digit_q;
    has_comma_d    = has_comma_q;
    count_d        = count_q;
    plan_pre       = 1'b0;
    plan_char      = 1'b1;
    plan_post      = 1'b0;
    plan_flush_app = multi;
    plan_char_app  = multi;
    plan_len       = count_q;
    wr_en          = 1'b0;
    if (cmd_i.accept) begin
      unique case (char_in_i) inside
        ChBackslash: begin
          escape_d = !escape_q;
          caret_d  = 1'b0;
          word_d   = 1'b0;
          nword_d  = 1'b0;
        end
        ChLBracket, ChRBracket: begin
          if (!escape_q) begin
            bracket_d = (char_in_i == ChLBracket);
          end
          escape_d = 1'b0;
          caret_d  = 1'b0;
          word_d   = 1'b0;
          nword_d  = 1'b0;
        end
        ChLParen: begin
          if (!escape_q && (paren_q != ParenMax)) begin
            paren_d = paren_q + 8'd1;
          end
          escape_d = 1'b0;
          caret_d  = 1'b0;
          word_d   = 1'b0;
          nword_d  = 1'b0;
        end
        ChRParen: begin
          if (!escape_q && (paren_q != '0)) begin
            paren_d = paren_q - 8'd1;
          end
          escape_d = 1'b0;
          caret_d  = 1'b0;
          word_d   = 1'b0;
          nword_d  = 1'b0;
        end
        ChLBrace: begin
          if (!escape_q && !bracket_q) begin
            if (brace_full) begin
              plan_pre    = 1'b1;
              pending_d   = 1'b0;
              has_digit_d = 1'b0;
              has_comma_d = 1'b0;
              count_d     = '0;
            end else begin
              pending_d = 1'b1;
              wr_en     = 1'b1;
              count_d   = count_q + CntW'(1);
              plan_char = 1'b0;
            end
          end
          escape_d = 1'b0;
          caret_d  = 1'b0;
          word_d   = 1'b0;
          nword_d  = 1'b0;
        end
        ChRBrace: begin
          // A closed quantifier is appended to the current component.
          if (pending_q && has_digit_q) begin
            plan_pre       = 1'b1;
            plan_flush_app = 1'b1;
            plan_char_app  = 1'b1;
            pending_d      = 1'b0;
            has_digit_d    = 1'b0;
            has_comma_d    = 1'b0;
            count_d        = '0;
          end
          escape_d = 1'b0;
          caret_d  = 1'b0;
          word_d   = 1'b0;
          nword_d  = 1'b0;
        end
        ChPlus, ChStar, ChQuest, ChDollar: begin
          plan_char_app = 1'b1;
          escape_d      = 1'b0;
          caret_d       = 1'b0;
          word_d        = 1'b0;
          nword_d       = 1'b0;
        end
        ChCaret: begin
          if (!escape_q) begin
            caret_d = 1'b1;
          end
          escape_d = 1'b0;
          word_d   = 1'b0;
          nword_d  = 1'b0;
        end
        ChLowB: begin
          word_d   = escape_q;
          escape_d = 1'b0;
          caret_d  = 1'b0;
          nword_d  = 1'b0;
        end
        ChUpB: begin
          nword_d  = escape_q;
          escape_d = 1'b0;
          caret_d  = 1'b0;
        end
        default: begin
          if (pending_q) begin
            if (brace_ok && !brace_full) begin
              has_digit_d = 1'b1;
              if (is_comma) begin
                has_comma_d = 1'b1;
              end
              wr_en     = 1'b1;
              count_d   = count_q + CntW'(1);
              plan_char = 1'b0;
            end else begin
              // Malformed or overfull: give the buffer up as literals.
              plan_pre    = 1'b1;
              pending_d   = 1'b0;
              has_digit_d = 1'b0;
              has_comma_d = 1'b0;
              count_d     = '0;
            end
          end
          escape_d = 1'b0;
          caret_d  = 1'b0;
          word_d   = 1'b0;
          nword_d  = 1'b0;
        end
      endcase

      plan_len = plan_pre ? count_q : count_d;

      if (end_of_expr_i) begin
        plan_post   = pending_d;
        escape_d    = 1'b0;
        caret_d     = 1'b0;
        word_d      = 1'b0;
        nword_d     = 1'b0;
        bracket_d   = 1'b0;
        paren_d     = '0;
        pending_d   = 1'b0;
        has_digit_d = 1'b0;
        has_comma_d = 1'b0;
        count_d     = '0;
      end
    end
  end

  always_comb begin
    if (cmd_i.accept) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IdxW'(1);
    end else begin
      idx_d = idx_q;
    end
  end

  always_comb begin
    comp_open_d = comp_open_q;
    if (cmd_i.load) begin
      comp_open_d = !(cmd_i.run_end && eoe_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_q    <= 1'b0;
      caret_q     <= 1'b0;
      word_q      <= 1'b0;
      nword_q     <= 1'b0;
      bracket_q   <= 1'b0;
      paren_q     <= '0;
      pending_q   <= 1'b0;
      has_digit_q <= 1'b0;
      has_comma_q <= 1'b0;
      count_q     <= '0;
      comp_open_q <= 1'b0;
      pre_q       <= 1'b0;
      do_char_q   <= 1'b0;
      post_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      escape_q    <= escape_d;
      caret_q     <= caret_d;
      word_q      <= word_d;
      nword_q     <= nword_d;
      bracket_q   <= bracket_d;
      paren_q     <= paren_d;
      pending_q   <= pending_d;
      has_digit_q <= has_digit_d;
      has_comma_q <= has_comma_d;
      count_q     <= count_d;
      comp_open_q <= comp_open_d;
      idx_q       <= idx_d;
      if (cmd_i.accept) begin
        pre_q     <= plan_pre;
        do_char_q <= plan_char;
        post_q    <= plan_post;
      end
      out_valid_q <= cmd_i.load || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      flush_app_q <= plan_flush_app;
      char_app_q  <= plan_char_app;
      len_q       <= plan_len;
      char_q      <= char_in_i;
      eoe_q       <= end_of_expr_i;
    end
    if (cmd_i.load) begin
      out_char_q <= cmd_i.sel_char ? char_q : rdata_q;
      out_new_q  <= !(beat_app && comp_open_q);
      out_last_q <= cmd_i.run_end;
    end
  end

  // Brace buffer, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[count_q[IdxW-1:0]] <= char_in_i;
    end
    rdata_q <= store_q[idx_d];
  end

  assign beat_app = cmd_i.sel_char ? char_app_q : flush_app_q;
  assign out_free = !out_valid_q || out_ready_i;

  assign stat_o.pre_flush  = pre_q;
  assign stat_o.do_char    = do_char_q;
  assign stat_o.post_flush = post_q;
  assign stat_o.idx_last   = ((CntW'(idx_q) + CntW'(1)) == len_q);
  assign stat_o.out_free   = out_free;

  assign out_valid_o   = out_valid_q;
  assign char_out_o    = out_char_q;
  assign new_part_o    = out_new_q;
  assign last_of_run_o = out_last_q;

endmodule

`default_nettype wire

[rtl/core/rcs_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module rcs_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_last_i
);

  // A result beat waits until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat withdrawn while stalled");

  // One item at a time: no second beat straight after an accepted one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again directly after a beat");

  // The beats of one item follow each other without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i)
    else $error("gap inside a run of result beats");

  // New input is taken only once the current run is complete.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> !(out_valid_i && !out_last_i))
    else $error("input ready while a run is unfinished");

endmodule

bind regex_component_splitter rcs_checker u_rcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_last_i  (out_o.last_of_run)
);

`default_nettype wire

[dv/rcs_stream_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the splitter. Every accepted character is run
// through a shadow of the splitter's state to work out the beats it should
// cause, and every output beat is compared against the oldest of those.
module rcs_stream_checker
  import rcs_pkg::*;
#(
  parameter int unsigned BraceDepth = BraceDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rcs_in_if           char_mon,
  rcs_out_if          part_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned beats_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       new_part;
    logic       last_of_run;
  } part_beat_t;

  // Shadow copy of the splitter state.
  logic        esc_q, caret_q, wstart_q, nwstart_q, bracket_q;
  logic [7:0]  depth_q;
  logic        brace_pend_q, brace_dig_q, brace_com_q, part_open_q;
  logic [7:0]  brace_buf_q [BraceDepth];
  int unsigned brace_fill_q;

  part_beat_t  beats_due_q [$];
  int unsigned step_beats;
  int unsigned fails;
  int unsigned compared;

  task automatic clear_marks();
    esc_q     = 1'b0;
    caret_q   = 1'b0;
    wstart_q  = 1'b0;
    nwstart_q = 1'b0;
  endtask

  task automatic clear_brace();
    brace_pend_q = 1'b0;
    brace_dig_q  = 1'b0;
    brace_com_q  = 1'b0;
    brace_fill_q = 0;
  endtask

  // The buffer contents are left alone: only filled entries are ever read.
  task automatic clear_all();
    clear_marks();
    bracket_q   = 1'b0;
    depth_q     = '0;
    clear_brace();
    part_open_q = 1'b0;
  endtask

  task automatic add_beat(input logic [7:0] ch, input logic append);
    part_beat_t b;
    b.ch          = ch;
    b.new_part    = !(append && part_open_q);
    b.last_of_run = 1'b0;
    beats_due_q = {beats_due_q, b};
    part_open_q = 1'b1;
    step_beats++;
  endtask

  task automatic flush_brace(input logic append);
    for (int unsigned i = 0; i < brace_fill_q; i++) begin
      add_beat(brace_buf_q[i], append);
    end
    clear_brace();
  endtask

  // Works out the beats caused by one accepted character.
  task automatic split_char(input logic [7:0] ch, input logic eoe);
    logic       esc0;
    logic       append;
    logic       is_digit;
    logic       is_comma;
    esc0   = esc_q;
    append = bracket_q || (depth_q != 0) || esc_q || caret_q || wstart_q || nwstart_q;
    step_beats = 0;
    case (ch)
      ChBackslash: begin
        add_beat(ch, append);
        esc_q     = !esc_q;
        caret_q   = 1'b0;
        wstart_q  = 1'b0;
        nwstart_q = 1'b0;
      end
      ChLBracket: begin
        add_beat(ch, append);
        if (!esc0) bracket_q = 1'b1;
        clear_marks();
      end
      ChRBracket: begin
        add_beat(ch, append);
        if (!esc0) bracket_q = 1'b0;
        clear_marks();
      end
      ChLParen: begin
        if (!esc0 && depth_q != ParenMax) depth_q++;
        add_beat(ch, append);
        clear_marks();
      end
      ChRParen: begin
        if (!esc0 && depth_q != 0) depth_q--;
        add_beat(ch, append);
        clear_marks();
      end
      ChLBrace: begin
        if (!esc0 && !bracket_q) begin
          if (brace_fill_q >= BraceDepth) begin
            flush_brace(append);
            add_beat(ch, append);
          end else begin
            brace_pend_q = 1'b1;
            brace_buf_q[brace_fill_q] = ch;
            brace_fill_q++;
          end
        end else begin
          add_beat(ch, append);
        end
        clear_marks();
      end
      ChRBrace: begin
        if (brace_pend_q && brace_dig_q) begin
          flush_brace(1'b1);
          add_beat(ch, 1'b1);
        end else begin
          add_beat(ch, append);
        end
        clear_marks();
      end
      ChPlus, ChStar, ChQuest, ChDollar: begin
        add_beat(ch, 1'b1);
        clear_marks();
      end
      ChCaret: begin
        if (!esc0) caret_q = 1'b1;
        add_beat(ch, append);
        esc_q     = 1'b0;
        wstart_q  = 1'b0;
        nwstart_q = 1'b0;
      end
      ChLowB: begin
        wstart_q = esc0;
        add_beat(ch, append);
        esc_q     = 1'b0;
        caret_q   = 1'b0;
        nwstart_q = 1'b0;
      end
      ChUpB: begin
        nwstart_q = esc0;
        add_beat(ch, append);
        esc_q   = 1'b0;
        caret_q = 1'b0;
      end
      default: begin
        if (brace_pend_q) begin
          is_digit = (ch >= ChZero) && (ch <= ChNine);
          is_comma = (ch == ChComma);
          if ((is_digit || (is_comma && brace_dig_q && !brace_com_q)) &&
              brace_fill_q < BraceDepth) begin
            brace_dig_q = 1'b1;
            if (is_comma) brace_com_q = 1'b1;
            brace_buf_q[brace_fill_q] = ch;
            brace_fill_q++;
          end else begin
            flush_brace(append);
            add_beat(ch, append);
          end
        end else begin
          add_beat(ch, append);
        end
        clear_marks();
      end
    endcase

    if (eoe) begin
      if (brace_pend_q) flush_brace(append);
      clear_all();
    end

    if (step_beats != 0) begin
      beats_due_q[beats_due_q.size() - 1].last_of_run = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what);
    fails++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_beat(input logic [7:0] ch, input logic np, input logic lr);
    part_beat_t want;
    if (beats_due_q.size() == 0) begin
      report_mismatch($sformatf("beat 0x%02h arrived with nothing predicted", ch));
    end else begin
      want = beats_due_q.pop_front();
      compared++;
      if (ch !== want.ch)
        report_mismatch($sformatf("beat %0d char_out 0x%02h, predicted 0x%02h",
                                  compared, ch, want.ch));
      if (np !== want.new_part)
        report_mismatch($sformatf("beat %0d new_part %b, predicted %b",
                                  compared, np, want.new_part));
      if (lr !== want.last_of_run)
        report_mismatch($sformatf("beat %0d last_of_run %b, predicted %b",
                                  compared, lr, want.last_of_run));
    end
  endtask

  // Prediction runs before the comparison; a character never produces a
  // beat at the edge where it is taken, so the order is only a formality.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_all();
      beats_due_q.delete();
      fails        = 0;
      compared     = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      beats_o      <= 0;
    end else begin
      if (char_mon.valid && char_mon.ready)
        split_char(char_mon.char_in, char_mon.end_of_expr);
      if (part_mon.valid && part_mon.ready)
        check_beat(part_mon.char_out, part_mon.new_part, part_mon.last_of_run);
      fail_count_o <= fails;
      pending_o    <= beats_due_q.size();
      beats_o      <= compared;
    end
  end

endmodule

[dv/tb_regex_component_splitter.sv]
`timescale 1ns / 1ps

// Top level of the splitter testbench. It makes the clock and the single
// reset, feeds expressions into the character channel, applies random
// back-pressure on the component channel and gives the verdict. All the
// prediction and comparison lives in the checker instantiated beside the
// block.
module tb_regex_component_splitter;
  import rcs_pkg::*;

  localparam int unsigned IdlePct       = 11;   // chance of a gap, per cycle
  localparam int unsigned RandomItems   = 170;
  localparam int unsigned NestRun       = 4;    // a few levels of grouping
  localparam int unsigned WatchdogLimit = 2000;
  // The longest beat sequence comes from flushing a full buffer, so this is ample
  // for anything still in flight once nothing is predicted any more.
  localparam int unsigned DrainCycles   = BraceDepthDef + 8;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic steady;   // when set, neither side idles

  int unsigned chars_sent;
  int unsigned exprs_sent;
  int unsigned random_sent;
  int unsigned idle_cycles;
  int unsigned fail_count;
  int unsigned beats_pending;
  int unsigned beats_checked;

  logic [7:0] text_q [$];

  rcs_in_if  char_if ();
  rcs_out_if part_if ();

  regex_component_splitter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_if),
    .out_o  (part_if)
  );

  rcs_stream_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_mon     (char_if),
    .part_mon     (part_if),
    .fail_count_o (fail_count),
    .pending_o    (beats_pending),
    .beats_o      (beats_checked)
  );

  always #5 clk_i = ~clk_i;

  // The receiver stalls about one cycle in nine, except during the steady
  // stretch. Exactly one assignment to ready per edge.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      part_if.ready <= 1'b0;
    end else begin
      part_if.ready <= steady || ($urandom_range(99, 0) >= IdlePct);
    end
  end

  // The watchdog only counts cycles with no beat moving on either channel,
  // so a long but healthy run never trips it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((char_if.valid && char_if.ready) || (part_if.valid && part_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == WatchdogLimit) begin
        $display("No beat moved for %0d cycles.", WatchdogLimit);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offers one character and holds it until it is taken. A gap lowers
  // valid for whole cycles before the character is offered, so valid is
  // never lowered and raised again at the same edge.
  task automatic send_char(input logic [7:0] ch, input logic eoe);
    while (!steady && $urandom_range(99, 0) < IdlePct) begin
      char_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_if.valid       <= 1'b1;
    char_if.char_in     <= ch;
    char_if.end_of_expr <= eoe;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
    chars_sent++;
  endtask

  // Sends the collected expression, marking its final character.
  task automatic send_expr();
    for (int i = 0; i < text_q.size(); i++) begin
      send_char(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();
    exprs_sent++;
  endtask

  task automatic add_text_byte(input logic [7:0] b);
    text_q = {text_q, b};
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) add_text_byte(s[i]);
  endtask

  task automatic push_digits(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      add_text_byte(ChZero + 8'($urandom_range(9, 0)));
    end
  endtask

  function automatic logic [7:0] pick_from(input string s);
    return s[$urandom_range(s.len() - 1, 0)];
  endfunction

  initial begin : stimulus
    string plain_set;
    string special_set;
    int    n_tok;
    int    kind;
    int    start_len;

    plain_set   = "acdxyzAQZ079_.-|";
    special_set = "\\[](){}+*?^$bB.,";

    chars_sent  = 0;
    exprs_sent  = 0;
    random_sent = 0;
    steady      = 1'b0;

    rst_ni              <= 1'b0;
    char_if.valid       <= 1'b0;
    char_if.char_in     <= '0;
    char_if.end_of_expr <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A quantifier with nothing before it opens a component;
    // escape, word boundaries in both forms, caret, brackets and a group all
    // switch the next character into the current component; a well-formed
    // {n,m} is held back and then appended; the byte extremes ride along.
    push_text("+a\\bc\\Bd^x[y](z)b{2,5}");
    add_text_byte(8'h00);
    add_text_byte(8'hFF);
    send_expr();
    // A quantifier still in the buffer when the expression ends is flushed.
    push_text("{3");
    send_expr();

    // Nest a few levels and then unwind past zero.
    for (int i = 0; i < NestRun; i++) add_text_byte(ChLParen);
    for (int i = 0; i < NestRun + 2; i++) add_text_byte(ChRParen);
    push_text("q");
    send_expr();

    // Random expressions built from tokens. Most are legal constructs with
    // random content; the rest are stray bytes and broken brace groups.
    while (random_sent < RandomItems) begin
      steady <= (random_sent >= 60) && (random_sent < 130);
      n_tok  = $urandom_range(10, 1);
      for (int t = 0; t < n_tok; t++) begin
        kind = $urandom_range(15, 0);
        case (kind)
          0, 1, 2: add_text_byte(pick_from(plain_set));
          3:       add_text_byte(8'($urandom_range(255, 0)));
          4: begin
            add_text_byte(ChBackslash);
            add_text_byte(pick_from(special_set));
          end
          5: begin
            if ($urandom_range(1, 0)) add_text_byte(ChBackslash);
            add_text_byte($urandom_range(1, 0) ? ChLowB : ChUpB);
          end
          6: add_text_byte(ChCaret);
          7: begin
            add_text_byte(ChLBracket);
            for (int j = $urandom_range(3, 1); j > 0; j--) begin
              add_text_byte(pick_from(plain_set));
            end
            add_text_byte(ChRBracket);
          end
          8:  add_text_byte(ChLParen);
          9:  add_text_byte(ChRParen);
          10: add_text_byte(pick_from("+*?$"));
          11, 12, 13: begin
            // {n}, {n,} or {n,m}; never more than the buffer holds.
            add_text_byte(ChLBrace);
            push_digits($urandom_range(3, 1));
            if ($urandom_range(1, 0)) begin
              add_text_byte(ChComma);
              push_digits($urandom_range(2, 0));
            end
            add_text_byte(ChRBrace);
          end
          14: begin
            add_text_byte(ChLBrace);
            case ($urandom_range(5, 0))
              0: add_text_byte(ChComma);                    // comma with no digit
              1: begin                                      // second comma
                push_digits(1);
                push_text(",,");
              end
              2: push_digits($urandom_range(9, 7));         // full or overfull with digits
              3: add_text_byte(ChRBrace);                   // closed before a digit
              4: push_digits(1);                            // left open
              default: begin                                // run of braces, up to overfull
                for (int j = $urandom_range(9, 6); j > 0; j--) add_text_byte(ChLBrace);
              end
            endcase
          end
          default: begin
            // A brace that is escaped or sits inside brackets is literal.
            if ($urandom_range(1, 0)) begin
              push_text("\\{");
            end else begin
              push_text("[{]");
            end
          end
        endcase
      end
      start_len = text_q.size();
      send_expr();
      random_sent += start_len;
    end

    steady <= 1'b0;
    char_if.valid <= 1'b0;
    @(posedge clk_i);
    while (beats_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d characters in %0d expressions; %0d output beats compared.",
             chars_sent, exprs_sent, beats_checked);
    $display("Covered anchors, escapes, word boundaries, brackets, nesting down past zero %s",
             "and legal, broken and overfull brace quantifiers.");
    if (beats_pending != 0) $display("%0d predicted beats never arrived.", beats_pending);
    if (fail_count == 0 && beats_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
